[rtl/sit_pkg.sv]
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the segment intersection test pipeline.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int PAR_BITS    = 34;
  localparam int QUOT_BITS   = 33;
  localparam int TOL_BITS    = 51;
  localparam int MARGIN_BITS = 21;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 21'd107;

  localparam logic REG_TOL    = 1'b0;
  localparam logic REG_MARGIN = 1'b1;

  localparam logic [1:0] KIND_NORMAL    = 2'd0;
  localparam logic [1:0] KIND_PARALLEL  = 2'd1;
  localparam logic [1:0] KIND_COLLINEAR = 2'd2;
  localparam logic [1:0] KIND_ZERO_LEN  = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       neg_first;
    logic       neg_second;
  } sit_ctrl_t;

endpackage

[rtl/sit_if.sv]
// ----------------------------------------------------------------------------
// sit_if
// Valid/ready channels for segment pairs and intersection results.
// ----------------------------------------------------------------------------
interface sit_in_if #(parameter int COORD_BITS = 24);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source(output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                 b_start_x, b_start_y, b_end_x, b_end_y, input ready);
  modport sink(input valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sit_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic signed [33:0] param_first;
  logic signed [33:0] param_second;

  modport source(output valid, hit, param_first, param_second, input ready);
  modport sink(input valid, hit, param_first, param_second, output ready);
endinterface

[rtl/segment_intersection_test_core.sv]
// ----------------------------------------------------------------------------
// segment_intersection_test_core
// Intersection test of two 2D segments with Q3.30 parameters.
// ----------------------------------------------------------------------------
// seg_in takes one segment pair per transaction; seg_out returns one result
// (hit, param_first, param_second) per transaction, in order.
// cfg_wr_en/cfg_index/cfg_wr_data write the tolerance (index 0) and the
// parameter margin (index 1); write only while no transaction is in flight.
// path from seg_in to seg_out: differences, products, cross products and case
//   selection in sit_front, then the sit_div divider (one quotient bit per stage),
//   then the output register in sit_back.
// throughput: one transaction per cycle while seg_out takes results, set by the fully pipelined divider.
// when seg_out is not ready while valid, the whole pipeline holds and
// seg_in.ready drops; nothing in flight is lost or repeated.
// reset clears all valid bits, tolerance to 0 and margin to 107.
// ----------------------------------------------------------------------------
module segment_intersection_test_core #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 30
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [sit_pkg::TOL_BITS-1:0]     cfg_wr_data,
  sit_in_if.sink                           seg_in,
  sit_out_if.source                        seg_out
);
  import sit_pkg::*;

  localparam int W = 2*COORD_BITS + 3;

  logic [TOL_BITS-1:0]    tol;
  logic [MARGIN_BITS-1:0] margin;
  logic                   adv;

  sit_ctrl_t ctrl_f, ctrl_d;
  logic [W-1:0] n_first, n_second, d;
  logic [QUOT_BITS-1:0] q_first, q_second;
  logic sat_first, sat_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol    <= '0;
      margin <= MARGIN_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == REG_TOL) begin
        tol <= cfg_wr_data;
      end else if (cfg_index == REG_MARGIN) begin
        margin <= cfg_wr_data[MARGIN_BITS-1:0];
      end
    end
  end

  assign adv          = !seg_out.valid || seg_out.ready;
  assign seg_in.ready = adv;

  sit_front #(.C(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (seg_in.valid),
    .a_start_x(seg_in.a_start_x),
    .a_start_y(seg_in.a_start_y),
    .a_end_x  (seg_in.a_end_x),
    .a_end_y  (seg_in.a_end_y),
    .b_start_x(seg_in.b_start_x),
    .b_start_y(seg_in.b_start_y),
    .b_end_x  (seg_in.b_end_x),
    .b_end_y  (seg_in.b_end_y),
    .tol      (tol),
    .ctrl     (ctrl_f),
    .n_first  (n_first),
    .n_second (n_second),
    .d        (d)
  );

  sit_div #(.W(W), .F(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctrl_in   (ctrl_f),
    .n_first   (n_first),
    .n_second  (n_second),
    .d         (d),
    .ctrl_out  (ctrl_d),
    .q_first   (q_first),
    .q_second  (q_second),
    .sat_first (sat_first),
    .sat_second(sat_second)
  );

  sit_back #(.F(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .ctrl        (ctrl_d),
    .q_first     (q_first),
    .q_second    (q_second),
    .sat_first   (sat_first),
    .sat_second  (sat_second),
    .margin      (margin),
    .valid       (seg_out.valid),
    .hit         (seg_out.hit),
    .param_first (seg_out.param_first),
    .param_second(seg_out.param_second)
  );

endmodule

[rtl/sit_front.sv]
// ----------------------------------------------------------------------------
// sit_front
// Differences, products, cross products and case selection (four stages).
// ----------------------------------------------------------------------------
module sit_front #(
  parameter int C = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   adv,
  input  logic                                   in_valid,
  input  logic signed [C-1:0]                    a_start_x,
  input  logic signed [C-1:0]                    a_start_y,
  input  logic signed [C-1:0]                    a_end_x,
  input  logic signed [C-1:0]                    a_end_y,
  input  logic signed [C-1:0]                    b_start_x,
  input  logic signed [C-1:0]                    b_start_y,
  input  logic signed [C-1:0]                    b_end_x,
  input  logic signed [C-1:0]                    b_end_y,
  input  logic [sit_pkg::TOL_BITS-1:0]           tol,
  output sit_pkg::sit_ctrl_t                     ctrl,
  output logic [2*C+2:0]                         n_first,
  output logic [2*C+2:0]                         n_second,
  output logic [2*C+2:0]                         d
);
  import sit_pkg::*;

  localparam int W  = 2*C+3;
  localparam int P  = 2*C+2;
  localparam int CW = (W > TOL_BITS) ? W : TOL_BITS;

  logic v1, v2, v3;
  logic signed [C:0] ux1, uy1, vx1, vy1, sx1, sy1, ex1, ey1;
  logic signed [C:0] ux2, uy2, sx2, sy2, ex2, ey2;
  logic signed [C:0] ux3, uy3, sx3, sy3, ex3, ey3;
  logic signed [P-1:0] p0, p1, p2, p3, p4, p5;
  logic signed [W-1:0] den3, nt3, nu3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ux1 <= (C+1)'(a_end_x) - (C+1)'(a_start_x);
      uy1 <= (C+1)'(a_end_y) - (C+1)'(a_start_y);
      vx1 <= (C+1)'(b_start_x) - (C+1)'(b_end_x);
      vy1 <= (C+1)'(b_start_y) - (C+1)'(b_end_y);
      sx1 <= (C+1)'(b_start_x) - (C+1)'(a_start_x);
      sy1 <= (C+1)'(b_start_y) - (C+1)'(a_start_y);
      ex1 <= (C+1)'(b_end_x) - (C+1)'(a_start_x);
      ey1 <= (C+1)'(b_end_y) - (C+1)'(a_start_y);

      p0 <= P'(ux1) * P'(vy1);
      p1 <= P'(vx1) * P'(uy1);
      p2 <= P'(sx1) * P'(vy1);
      p3 <= P'(vx1) * P'(sy1);
      p4 <= P'(ux1) * P'(sy1);
      p5 <= P'(sx1) * P'(uy1);
      ux2 <= ux1;
      uy2 <= uy1;
      sx2 <= sx1;
      sy2 <= sy1;
      ex2 <= ex1;
      ey2 <= ey1;

      den3 <= W'(p0) - W'(p1);
      nt3  <= W'(p2) - W'(p3);
      nu3  <= W'(p4) - W'(p5);
      ux3 <= ux2;
      uy3 <= uy2;
      sx3 <= sx2;
      sy3 <= sy2;
      ex3 <= ex2;
      ey3 <= ey2;
    end
  end

  logic [W-1:0] abs_den, abs_nt, abs_nu;
  logic [C:0] abs_ux, abs_uy, abs_len, abs_n3, abs_n4;
  logic signed [C:0] len, n3, n4;
  logic use_x, is_par, is_col;
  logic [CW-1:0] thr;
  logic [1:0] kind;

  always_comb begin
    abs_den = den3[W-1] ? W'(-den3) : W'(den3);
    abs_nt  = nt3[W-1] ? W'(-nt3) : W'(nt3);
    abs_nu  = nu3[W-1] ? W'(-nu3) : W'(nu3);
    abs_ux  = ux3[C] ? (C+1)'(-ux3) : (C+1)'(ux3);
    abs_uy  = uy3[C] ? (C+1)'(-uy3) : (C+1)'(uy3);
    use_x   = abs_ux > abs_uy;
    len     = use_x ? ux3 : uy3;
    n3      = use_x ? sx3 : sy3;
    n4      = use_x ? ex3 : ey3;
    abs_len = use_x ? abs_ux : abs_uy;
    abs_n3  = n3[C] ? (C+1)'(-n3) : (C+1)'(n3);
    abs_n4  = n4[C] ? (C+1)'(-n4) : (C+1)'(n4);
    thr     = (tol == '0) ? CW'(1) : CW'(tol);
    is_par  = CW'(abs_den) < thr;
    is_col  = is_par && (CW'(abs_nt) < thr);
    if (!is_par) begin
      kind = KIND_NORMAL;
    end else if (!is_col) begin
      kind = KIND_PARALLEL;
    end else if (len == '0) begin
      kind = KIND_ZERO_LEN;
    end else begin
      kind = KIND_COLLINEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (adv) begin
      ctrl.valid      <= v3;
      ctrl.kind       <= kind;
      ctrl.neg_first  <= is_par ? (n3[C] ^ len[C]) : (nt3[W-1] ^ den3[W-1]);
      ctrl.neg_second <= is_par ? (n4[C] ^ len[C]) : (nu3[W-1] ^ den3[W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_first  <= is_par ? W'(abs_n3) : abs_nt;
      n_second <= is_par ? W'(abs_n4) : abs_nu;
      d        <= is_par ? W'(abs_len) : abs_den;
    end
  end

endmodule

[rtl/sit_div.sv]
// ----------------------------------------------------------------------------
// sit_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sit_div #(
  parameter int W = 51,
  parameter int F = 30
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            adv,
  input  sit_pkg::sit_ctrl_t              ctrl_in,
  input  logic [W-1:0]                    n_first,
  input  logic [W-1:0]                    n_second,
  input  logic [W-1:0]                    d,
  output sit_pkg::sit_ctrl_t              ctrl_out,
  output logic [sit_pkg::QUOT_BITS-1:0]   q_first,
  output logic [sit_pkg::QUOT_BITS-1:0]   q_second,
  output logic                            sat_first,
  output logic                            sat_second
);
  import sit_pkg::*;

  localparam int N  = QUOT_BITS;
  localparam int IW = QUOT_BITS - F;

  sit_ctrl_t        ctrl [0:N];
  logic [W-1:0]     dd   [0:N];
  logic [W-1:0]     r1   [0:N];
  logic [W-1:0]     r2   [0:N];
  logic [N-1:0]     q1   [0:N];
  logic [N-1:0]     q2   [0:N];
  logic [IW-1:0]    lo1  [0:N];
  logic [IW-1:0]    lo2  [0:N];
  logic             s1   [0:N];
  logic             s2   [0:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl[0] <= '0;
    end else if (adv) begin
      ctrl[0] <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dd[0]  <= d;
      r1[0]  <= n_first >> IW;
      r2[0]  <= n_second >> IW;
      q1[0]  <= '0;
      q2[0]  <= '0;
      lo1[0] <= n_first[IW-1:0];
      lo2[0] <= n_second[IW-1:0];
      s1[0]  <= {{IW{1'b0}}, n_first} >= {d, {IW{1'b0}}};
      s2[0]  <= {{IW{1'b0}}, n_second} >= {d, {IW{1'b0}}};
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [W:0] t1, t2;
    logic ge1, ge2;

    assign t1  = {r1[k-1], lo1[k-1][IW-1]};
    assign t2  = {r2[k-1], lo2[k-1][IW-1]};
    assign ge1 = t1 >= {1'b0, dd[k-1]};
    assign ge2 = t2 >= {1'b0, dd[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl[k] <= '0;
      end else if (adv) begin
        ctrl[k] <= ctrl[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dd[k]  <= dd[k-1];
        r1[k]  <= ge1 ? W'(t1 - {1'b0, dd[k-1]}) : W'(t1);
        r2[k]  <= ge2 ? W'(t2 - {1'b0, dd[k-1]}) : W'(t2);
        q1[k]  <= {q1[k-1][N-2:0], ge1};
        q2[k]  <= {q2[k-1][N-2:0], ge2};
        lo1[k] <= lo1[k-1] << 1;
        lo2[k] <= lo2[k-1] << 1;
        s1[k]  <= s1[k-1];
        s2[k]  <= s2[k-1];
      end
    end
  end

  assign ctrl_out   = ctrl[N];
  assign q_first    = q1[N];
  assign q_second   = q2[N];
  assign sat_first  = s1[N];
  assign sat_second = s2[N];

endmodule

[rtl/sit_back.sv]
// ----------------------------------------------------------------------------
// sit_back
// Sign and saturation of the quotients, range checks and result register.
// ----------------------------------------------------------------------------
module sit_back #(
  parameter int F = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  sit_pkg::sit_ctrl_t                ctrl,
  input  logic [sit_pkg::QUOT_BITS-1:0]     q_first,
  input  logic [sit_pkg::QUOT_BITS-1:0]     q_second,
  input  logic                              sat_first,
  input  logic                              sat_second,
  input  logic [sit_pkg::MARGIN_BITS-1:0]   margin,
  output logic                              valid,
  output logic                              hit,
  output logic signed [sit_pkg::PAR_BITS-1:0] param_first,
  output logic signed [sit_pkg::PAR_BITS-1:0] param_second
);
  import sit_pkg::*;

  localparam int XW = PAR_BITS + 2;
  localparam logic [PAR_BITS-1:0] LIMIT = PAR_BITS'(1) << (PAR_BITS-1);
  localparam logic [PAR_BITS-1:0] Q_ONE = PAR_BITS'(1) << F;

  function automatic logic signed [PAR_BITS-1:0] fix_q(
    input logic [QUOT_BITS-1:0] q, input logic sat, input logic neg);
    logic [PAR_BITS-1:0] m;
    m = sat ? LIMIT : {1'b0, q};
    if (neg) begin
      fix_q = $signed(-m);
    end else if (sat) begin
      fix_q = $signed(LIMIT - PAR_BITS'(1));
    end else begin
      fix_q = $signed(m);
    end
  endfunction

  function automatic logic in_rng(
    input logic signed [PAR_BITS-1:0] q, input logic [MARGIN_BITS-1:0] mg);
    logic signed [XW-1:0] qe, lo, hi;
    qe = XW'(q);
    lo = -$signed(XW'(mg));
    hi = $signed(XW'(Q_ONE)) + $signed(XW'(mg));
    in_rng = (qe >= lo) && (qe <= hi);
  endfunction

  logic signed [PAR_BITS-1:0] v1, v2, pf_next, ps_next;
  logic in1, in2, hit_next;

  always_comb begin
    v1  = fix_q(q_first, sat_first, ctrl.neg_first);
    v2  = fix_q(q_second, sat_second, ctrl.neg_second);
    in1 = in_rng(v1, margin);
    in2 = in_rng(v2, margin);
    case (ctrl.kind)
      KIND_NORMAL: begin
        pf_next  = v1;
        ps_next  = in1 ? v2 : '0;
        hit_next = in1 && in2;
      end
      KIND_COLLINEAR: begin
        pf_next  = in2 ? v2 : v1;
        ps_next  = in2 ? $signed(Q_ONE) : '0;
        hit_next = in1 ^ in2;
      end
      default: begin
        pf_next  = '0;
        ps_next  = '0;
        hit_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit          <= hit_next;
      param_first  <= pf_next;
      param_second <= ps_next;
    end
  end

endmodule

[dv/sit_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sit_checker
// Watches the segment and result channels and the register writes, predicts
// hit and both Q3.30 parameters of every accepted segment pair and compares
// each result transaction with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sit_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_index,
  input  logic [sit_pkg::TOL_BITS-1:0] cfg_wr_data,
  sit_in_if                            seg_in,
  sit_out_if                           seg_out,
  output int                           errors,
  output int                           outstanding
);
  import sit_pkg::*;

  localparam int FRAC = 30;
  localparam longint Q_ONE = longint'(1) << FRAC;
  localparam longint unsigned SAT = longint'(1) << (PAR_BITS - 1);

  typedef struct {
    logic            hit;
    logic [PAR_BITS-1:0] first;
    logic [PAR_BITS-1:0] second;
  } verdict_t;

  verdict_t pending_verdicts[$];
  logic [TOL_BITS-1:0]    tolerance;
  logic [MARGIN_BITS-1:0] margin;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint quotient(longint n, longint d);
    longint unsigned un, ud, whole, rem, m, f;
    logic neg;
    un = mag(n);
    ud = mag(d);
    neg = (n < 0) != (d < 0);
    whole = un / ud;
    rem = un % ud;
    if (whole >= (SAT >> FRAC)) begin
      m = SAT;
    end else begin
      f = 0;
      for (int i = 0; i < FRAC; i++) begin
        rem = rem << 1;
        f = f << 1;
        if (rem >= ud) begin
          rem = rem - ud;
          f = f | 1;
        end
      end
      m = (whole << FRAC) | f;
    end
    if (neg) return -longint'(m);
    return longint'(m >= SAT ? SAT - 1 : m);
  endfunction

  function automatic logic in_range(longint q);
    longint mg;
    mg = longint'(margin);
    return q >= -mg && q <= Q_ONE + mg;
  endfunction

  function automatic verdict_t predict_pair(longint ax0, longint ay0, longint ax1,
                                            longint ay1, longint bx0, longint by0,
                                            longint bx1, longint by1);
    longint ux, uy, vx, vy, sx, sy, ex, ey, den, num_t, num_u, len, q3, q4;
    longint pf, ps;
    longint unsigned thr;
    logic along_x, in3, in4, h;
    verdict_t r;
    ux = ax1 - ax0; uy = ay1 - ay0;
    vx = bx0 - bx1; vy = by0 - by1;
    sx = bx0 - ax0; sy = by0 - ay0;
    ex = bx1 - ax0; ey = by1 - ay0;
    den = ux * vy - vx * uy;
    num_t = sx * vy - vx * sy;
    num_u = ux * sy - sx * uy;
    thr = (tolerance != 0) ? longint'(tolerance) : 1;
    h = 0; pf = 0; ps = 0;
    if (mag(den) < thr) begin
      if (mag(num_t) < thr) begin
        along_x = mag(ux) > mag(uy);
        len = along_x ? ux : uy;
        if (len != 0) begin
          q3 = quotient(along_x ? sx : sy, len);
          q4 = quotient(along_x ? ex : ey, len);
          in3 = in_range(q3);
          in4 = in_range(q4);
          pf = in4 ? q4 : q3;
          ps = in4 ? Q_ONE : 0;
          h = in3 != in4;
        end
      end
    end else begin
      pf = quotient(num_t, den);
      if (in_range(pf)) begin
        ps = quotient(num_u, den);
        h = in_range(ps);
      end
    end
    r.hit = h;
    r.first = pf[PAR_BITS-1:0];
    r.second = ps[PAR_BITS-1:0];
    return r;
  endfunction

  assign outstanding = pending_verdicts.size();

  always @(posedge clk) begin
    int bad;
    bad = 0;
    if (rst) begin
      tolerance <= '0;
      margin <= MARGIN_RESET;
      errors <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_TOL) tolerance <= cfg_wr_data;
        else margin <= cfg_wr_data[MARGIN_BITS-1:0];
      end
      if (seg_in.valid && seg_in.ready)
        pending_verdicts.push_back(predict_pair(seg_in.a_start_x, seg_in.a_start_y,
          seg_in.a_end_x, seg_in.a_end_y, seg_in.b_start_x, seg_in.b_start_y,
          seg_in.b_end_x, seg_in.b_end_y));
      if (seg_out.valid && seg_out.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result transaction with no prediction waiting");
          bad = bad + 1;
        end else begin
          verdict_t e;
          e = pending_verdicts.pop_front();
          if (seg_out.hit !== e.hit) begin
            $error("hit: expected %0b actual %0b", e.hit, seg_out.hit);
            bad = bad + 1;
          end
          if (seg_out.param_first !== e.first) begin
            $error("param_first: expected %0d actual %0d", $signed(e.first),
                   seg_out.param_first);
            bad = bad + 1;
          end
          if (seg_out.param_second !== e.second) begin
            $error("param_second: expected %0d actual %0d", $signed(e.second),
                   seg_out.param_second);
            bad = bad + 1;
          end
        end
      end
      errors <= errors + bad;
    end
  end
endmodule

[dv/tb_segment_intersection_test_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segment_intersection_test_core
// Drives directed and random segment pairs (crossing, touching, parallel,
// collinear, degenerate and fully random) through the core under several
// tolerance and margin settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_segment_intersection_test_core;
  import sit_pkg::*;

  localparam int LIMIT = 600000;

  typedef logic [7:0][23:0] pair_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_wr_en = 0;
  logic cfg_index = REG_TOL;
  logic [TOL_BITS-1:0] cfg_wr_data = '0;
  int errors, outstanding, cycles = 0;
  int src_idle = 0, snk_idle = 0;
  logic hold_go = 0;
  int hold_left = 0;

  sit_in_if  seg_in ();
  sit_out_if seg_out ();

  segment_intersection_test_core dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data), .seg_in(seg_in), .seg_out(seg_out)
  );

  sit_checker checker_i (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wr_data(cfg_wr_data), .seg_in(seg_in), .seg_out(seg_out),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    seg_in.valid = 0;
    {seg_in.a_start_x, seg_in.a_start_y, seg_in.a_end_x, seg_in.a_end_y,
     seg_in.b_start_x, seg_in.b_start_y, seg_in.b_end_x, seg_in.b_end_y} = '0;
    seg_out.ready = 0;
  end

  // receiver with random stalls and a long hold-off on request
  always @(posedge clk) begin
    if (hold_go && hold_left == 0) begin
      hold_left <= 400;
      seg_out.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      seg_out.ready <= 0;
    end else begin
      seg_out.ready <= !rst && ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("segment_intersection_test_core regression: fail");
      $finish;
    end
  end

  function automatic logic [23:0] rc(int bits);
    return 24'($urandom_range(0, (1 << bits) - 1) - (1 << (bits - 1)));
  endfunction

  function automatic pair_t mk(int ax0, int ay0, int ax1, int ay1, int bx0,
                               int by0, int bx1, int by1);
    pair_t p;
    p[0] = ax0[23:0]; p[1] = ay0[23:0]; p[2] = ax1[23:0]; p[3] = ay1[23:0];
    p[4] = bx0[23:0]; p[5] = by0[23:0]; p[6] = bx1[23:0]; p[7] = by1[23:0];
    return p;
  endfunction

  function automatic pair_t random_pair();
    int cx, cy, dx, dy, ex, ey, k, m, sel;
    cx = $signed(rc(22)); cy = $signed(rc(22));
    dx = $signed(rc(11)); dy = $signed(rc(11));
    ex = $signed(rc(11)); ey = $signed(rc(11));
    k = $urandom_range(0, 8) - 4; m = $urandom_range(0, 8) - 4;
    sel = $urandom_range(99);
    if (sel < 15) begin
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (sel < 50) begin
      // crossing near c, often touching ends
      return mk(cx - k * dx, cy - k * dy, cx + m * dx, cy + m * dy,
                cx - $urandom_range(0, 3) * ex, cy - $urandom_range(0, 3) * ey,
                cx + $urandom_range(0, 3) * ex, cy + $urandom_range(0, 3) * ey);
    end else if (sel < 62) begin
      // parallel with small offset
      return mk(cx, cy, cx + dx, cy + dy, cx + ex, cy + ey,
                cx + ex + k * dx, cy + ey + k * dy);
    end else if (sel < 85) begin
      // collinear
      return mk(cx, cy, cx + dx, cy + dy, cx + k * dx, cy + k * dy,
                cx + m * dx, cy + m * dy);
    end else if (sel < 92) begin
      // zero-length first segment
      return mk(cx, cy, cx, cy, cx + k * ex, cy + k * ey, cx + m * ex, cy + m * ey);
    end else begin
      return mk($urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4,
                $urandom_range(0, 8) - 4, $urandom_range(0, 8) - 4);
    end
  endfunction

  task automatic send(pair_t p);
    while ($urandom_range(99) < src_idle) begin
      seg_in.valid <= 0;
      @(posedge clk);
    end
    seg_in.valid <= 1;
    {seg_in.b_end_y, seg_in.b_end_x, seg_in.b_start_y, seg_in.b_start_x,
     seg_in.a_end_y, seg_in.a_end_x, seg_in.a_start_y, seg_in.a_start_x} <= p;
    @(posedge clk);
    while (!seg_in.ready) @(posedge clk);
  endtask

  task automatic drain();
    seg_in.valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [TOL_BITS-1:0] v);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  logic [TOL_BITS-1:0] tol_set[6] = '{0, 0, 51'h4_0000_0000_0000, 1000, 1, 5_000_000};
  logic [TOL_BITS-1:0] mg_set[6] = '{107, 0, 1048576, 0, 1048576, 2000};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed
    send(mk(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607, 8388607, -8388608));
    send(mk(8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    send(mk(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
            -8388608));
    send(mk(0, 0, 10, 0, 0, -5, 0, 5));
    send(mk(0, 0, 10, 0, 10, -5, 10, 5));
    send(mk(0, 0, 10, 0, 11, -5, 11, 5));
    send(mk(0, 0, 10, 0, 5, 0, 5, 5));
    send(mk(0, 0, 10, 0, 5, 1, 5, 5));
    send(mk(0, 0, 10, 0, 0, 1, 10, 1));
    send(mk(0, 0, 10, 0, 5, 0, 20, 0));
    send(mk(0, 0, 10, 0, -5, 0, 5, 0));
    send(mk(0, 0, 10, 0, 2, 0, 8, 0));
    send(mk(0, 0, 10, 0, 20, 0, 30, 0));
    send(mk(0, 0, 0, 10, 0, 5, 0, 15));
    send(mk(3, 3, 3, 3, 3, 3, 6, 6));
    send(mk(3, 3, 3, 3, 0, 0, 6, 6));
    send(mk(0, 0, 1, 0, -8388608, 1, 8388607, -1));
    send(mk(0, 0, 8388607, 1, 0, 1, 1, -8388608));
    send(mk(-8388608, 0, 8388607, 0, 0, 0, 0, 0));
    send(mk(0, 0, 3, 3, 3, 3, 9, 9));
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      repeat (45) @(posedge clk);
      write_reg(REG_TOL, tol_set[ph]);
      write_reg(REG_MARGIN, mg_set[ph]);
      src_idle = (ph / 2 == 0) ? 35 : (ph / 2 == 1) ? 52 : 0;
      snk_idle = (ph / 2 == 0) ? 52 : (ph / 2 == 1) ? 35 : 0;
      for (int i = 0; i < 215; i++) begin
        if (ph == 1 && i == 20) hold_go <= 1;
        if (ph == 1 && i == 21) hold_go <= 0;
        if (ph == 3 && i == 100) drain();
        send(random_pair());
      end
    end
    drain();
    repeat (45) @(posedge clk);
    if (errors == 0)
      $display("segment_intersection_test_core regression: pass");
    else
      $display("segment_intersection_test_core regression: fail");
    $finish;
  end
endmodule
